/* design/tcw_pkg.sv */
// shared field widths, mode codes and character codes of the text console writer
package tcw_pkg;

  localparam int MODE_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int COLOUR_W = 4;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int CELL_W   = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PRINT      = 2'd0,
    MODE_CLEAR      = 2'd1,
    MODE_SET_CURSOR = 2'd2,
    MODE_READ       = 2'd3
  } mode_t;

  localparam logic [CHAR_W-1:0] CH_NULL      = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

endpackage

/* design/tcw_cell_ram.sv */
// single-port-write, single-port-read cell memory with registered read data
module tcw_cell_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/text_console_char_writer.sv */
// text console writer: ROWS x COLUMNS cell store, cursor and command sequencer
//
// Usage: drive the in_ fields and raise start while busy is low; the item is
// taken at that clock edge. Exactly one result follows per item: out_valid is
// high for one cycle with the cursor after the step, the cell word (read mode
// only, else zero) and the scroll flag. The receiver cannot stall the block.
// Backspace, null, set cursor and a print that needs no fill walk raise the
// strobe straight from the execute state; a read first waits in ST_RDWAIT
// for the registered memory read data. A new item can be accepted in the
// strobe cycle.
// Walks over the cell memory make one write per cycle: a newline fills
// COLUMNS-1 minus the cursor column cells with spaces, a scroll blanks the
// COLUMNS cells of the new bottom row (rows sit in a circular buffer, so no
// copying), and clear writes all ROWS*COLUMNS cells.
// After reset the block holds busy high while it writes zero into every
// cell (ROWS*COLUMNS cells, 2000 at the default size); cursor resets to 0,0.
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [tcw_pkg::MODE_W-1:0]   in_mode,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::COLOUR_W-1:0] in_fg_colour,
  input  logic [tcw_pkg::COLOUR_W-1:0] in_bg_colour,
  input  logic [tcw_pkg::ROW_W-1:0]    in_target_row,
  input  logic [tcw_pkg::COL_W-1:0]    in_target_col,
  output logic                         out_valid,
  output logic [tcw_pkg::ROW_W-1:0]    out_cursor_row,
  output logic [tcw_pkg::COL_W-1:0]    out_cursor_col,
  output logic [tcw_pkg::CELL_W-1:0]   out_cell_word,
  output logic                         out_scrolled
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int RW    = $clog2(ROWS);
  localparam int RW1   = RW + 1;
  localparam int CW    = $clog2(COLUMNS);
  localparam int AW    = $clog2(DEPTH);
  localparam int RowW  = tcw_pkg::ROW_W;
  localparam int ColW  = tcw_pkg::COL_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_RDWAIT
  } state_t;

  // what to do once a fill walk reaches its last cell
  typedef enum logic [1:0] {
    AFT_EMIT,
    AFT_ADVANCE,
    AFT_SILENT
  } after_t;

  state_t                       state_r, state_nxt;
  after_t                       after_r, after_nxt;
  logic [RW-1:0]                cur_row_r, cur_row_nxt;
  logic [CW-1:0]                cur_col_r, cur_col_nxt;
  logic [RW-1:0]                base_r, base_nxt;
  logic [AW-1:0]                fill_addr_r, fill_addr_nxt;
  logic [AW-1:0]                fill_end_r, fill_end_nxt;
  logic [tcw_pkg::CELL_W-1:0]   fill_word_r, fill_word_nxt;
  logic                         scr_r, scr_nxt;
  logic                         rd_ok_r, rd_ok_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [tcw_pkg::CELL_W-1:0]   out_cell_r, out_cell_nxt;

  tcw_pkg::mode_t               req_mode_r;
  logic [tcw_pkg::CHAR_W-1:0]   req_char_r;
  logic [tcw_pkg::COLOUR_W-1:0] req_fg_r;
  logic [tcw_pkg::COLOUR_W-1:0] req_bg_r;
  logic [tcw_pkg::ROW_W-1:0]    req_trow_r;
  logic [tcw_pkg::COL_W-1:0]    req_tcol_r;

  logic [RW-1:0]                calc_row;
  logic [RW:0]                  psum;
  logic [RW-1:0]                phys_row;
  logic [AW-1:0]                row_addr;
  logic [AW-1:0]                base_addr;
  logic                         in_range;
  logic                         accept;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]   ram_rdata;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // logical row to physical row through the circular top-row pointer
  assign calc_row = (req_mode_r == tcw_pkg::MODE_READ) ? RW'(req_trow_r) : cur_row_r;
  assign psum     = {1'b0, calc_row} + {1'b0, base_r};
  assign phys_row = (psum >= RW1'(ROWS)) ? RW'(psum - RW1'(ROWS)) : RW'(psum);
  assign row_addr  = AW'(phys_row) * AW'(COLUMNS);
  assign base_addr = AW'(base_r) * AW'(COLUMNS);
  assign in_range  = (32'(req_trow_r) < 32'(ROWS)) && (32'(req_tcol_r) < 32'(COLUMNS));

  always_comb begin
    logic do_wrap;
    logic do_emit;
    state_nxt     = state_r;
    after_nxt     = after_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    base_nxt      = base_r;
    fill_addr_nxt = fill_addr_r;
    fill_end_nxt  = fill_end_r;
    fill_word_nxt = fill_word_r;
    scr_nxt       = scr_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_cell_nxt  = out_cell_r;
    ram_we        = 1'b0;
    ram_waddr     = row_addr + AW'(cur_col_r);
    ram_wdata     = {req_bg_r, req_fg_r, req_char_r};
    ram_re        = 1'b0;
    ram_raddr     = row_addr + AW'(req_tcol_r);
    do_wrap       = 1'b0;
    do_emit       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          scr_nxt   = 1'b0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (req_mode_r)
          tcw_pkg::MODE_PRINT: begin
            if (req_char_r == tcw_pkg::CH_BACKSPACE) begin
              if (cur_col_r != '0) begin
                ram_we      = 1'b1;
                ram_waddr   = row_addr + AW'(cur_col_r) - AW'(1);
                ram_wdata   = {req_bg_r, req_fg_r, tcw_pkg::CH_NULL};
                cur_col_nxt = cur_col_r - CW'(1);
              end
              do_emit = 1'b1;
            end else if (req_char_r == tcw_pkg::CH_NEWLINE) begin
              if (32'(cur_col_r) < 32'(COLUMNS - 1)) begin
                // blank up to the second-to-last column, then wrap
                fill_addr_nxt = row_addr + AW'(cur_col_r);
                fill_end_nxt  = row_addr + AW'(COLUMNS - 2);
                fill_word_nxt = {{(tcw_pkg::CELL_W - tcw_pkg::CHAR_W){1'b0}},
                                 tcw_pkg::CH_SPACE};
                after_nxt     = AFT_ADVANCE;
                state_nxt     = ST_FILL;
              end else begin
                do_wrap = 1'b1;
              end
            end else if (req_char_r == tcw_pkg::CH_NULL) begin
              do_emit = 1'b1;
            end else begin
              ram_we = 1'b1;
              if (32'(cur_col_r) == 32'(COLUMNS - 1)) begin
                do_wrap = 1'b1;
              end else begin
                cur_col_nxt = cur_col_r + CW'(1);
                do_emit     = 1'b1;
              end
            end
          end
          tcw_pkg::MODE_CLEAR: begin
            fill_addr_nxt = '0;
            fill_end_nxt  = AW'(DEPTH - 1);
            fill_word_nxt = {req_bg_r, {tcw_pkg::COLOUR_W{1'b0}}, tcw_pkg::CH_NULL};
            cur_row_nxt   = '0;
            cur_col_nxt   = '0;
            base_nxt      = '0;
            after_nxt     = AFT_EMIT;
            state_nxt     = ST_FILL;
          end
          tcw_pkg::MODE_SET_CURSOR: begin
            cur_row_nxt = (32'(req_trow_r) < 32'(ROWS)) ? RW'(req_trow_r) : RW'(ROWS - 1);
            cur_col_nxt = (32'(req_tcol_r) < 32'(COLUMNS)) ? CW'(req_tcol_r)
                                                          : CW'(COLUMNS - 1);
            do_emit = 1'b1;
          end
          tcw_pkg::MODE_READ: begin
            ram_re    = in_range;
            rd_ok_nxt = in_range;
            state_nxt = ST_RDWAIT;
          end
          default: begin
            do_emit = 1'b1;
          end
        endcase
      end
      ST_FILL: begin
        ram_we        = 1'b1;
        ram_waddr     = fill_addr_r;
        ram_wdata     = fill_word_r;
        fill_addr_nxt = fill_addr_r + AW'(1);
        if (fill_addr_r == fill_end_r) begin
          case (after_r)
            AFT_EMIT:    do_emit   = 1'b1;
            AFT_ADVANCE: do_wrap   = 1'b1;
            AFT_SILENT:  state_nxt = ST_IDLE;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RDWAIT: begin
        do_emit = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_wrap) begin
      cur_col_nxt = '0;
      if (32'(cur_row_r) < 32'(ROWS - 1)) begin
        cur_row_nxt = cur_row_r + RW'(1);
        do_emit     = 1'b1;
      end else begin
        // old top row becomes the new bottom row and gets blanked
        fill_addr_nxt = base_addr;
        fill_end_nxt  = base_addr + AW'(COLUMNS - 1);
        fill_word_nxt = '0;
        base_nxt      = (32'(base_r) == 32'(ROWS - 1)) ? '0 : base_r + RW'(1);
        scr_nxt       = 1'b1;
        after_nxt     = AFT_EMIT;
        state_nxt     = ST_FILL;
      end
    end

    if (do_emit) begin
      out_valid_nxt = 1'b1;
      out_cell_nxt  = (state_r == ST_RDWAIT && rd_ok_r) ? ram_rdata : '0;
      state_nxt     = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // reset sweep writes zero into every cell
      state_r     <= ST_FILL;
      after_r     <= AFT_SILENT;
      fill_addr_r <= '0;
      fill_end_r  <= AW'(DEPTH - 1);
      fill_word_r <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      base_r      <= '0;
      scr_r       <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_cell_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_end_r  <= fill_end_nxt;
      fill_word_r <= fill_word_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      base_r      <= base_nxt;
      scr_r       <= scr_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
      out_cell_r  <= out_cell_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode_r <= tcw_pkg::mode_t'(in_mode);
      req_char_r <= in_char_code;
      req_fg_r   <= in_fg_colour;
      req_bg_r   <= in_bg_colour;
      req_trow_r <= in_target_row;
      req_tcol_r <= in_target_col;
    end
  end

  tcw_cell_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_cursor_row = RowW'(cur_row_r);
  assign out_cursor_col = ColW'(cur_col_r);
  assign out_cell_word  = out_cell_r;
  assign out_scrolled   = scr_r;

endmodule

/* sim/tb_text_console_char_writer.sv */
// testbench for the text console writer: directed and random commands against a cell-level model
module tb_text_console_char_writer;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ModeW   = tcw_pkg::MODE_W;
  localparam int CharW   = tcw_pkg::CHAR_W;
  localparam int ColourW = tcw_pkg::COLOUR_W;
  localparam int RowW    = tcw_pkg::ROW_W;
  localparam int ColW    = tcw_pkg::COL_W;
  localparam int CellW   = tcw_pkg::CELL_W;

  typedef struct packed {
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [CellW-1:0] word;
    logic             scrolled;
  } console_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [ModeW-1:0]   in_mode;
  logic [CharW-1:0]   in_char_code;
  logic [ColourW-1:0] in_fg_colour;
  logic [ColourW-1:0] in_bg_colour;
  logic [RowW-1:0]    in_target_row;
  logic [ColW-1:0]    in_target_col;
  logic               out_valid;
  logic [RowW-1:0]    out_cursor_row;
  logic [ColW-1:0]    out_cursor_col;
  logic [CellW-1:0]   out_cell_word;
  logic               out_scrolled;

  // expected console state
  logic [CellW-1:0] screen_cells [CELLS];
  int               cursor_row_q;
  int               cursor_col_q;

  console_result_t expected_results [$];
  int              error_count;
  bit              idle_on;
  int              n_prints, n_clears, n_moves, n_reads, n_scrolls;

  text_console_char_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_char_code  (in_char_code),
    .in_fg_colour  (in_fg_colour),
    .in_bg_colour  (in_bg_colour),
    .in_target_row (in_target_row),
    .in_target_col (in_target_col),
    .out_valid     (out_valid),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col),
    .out_cell_word (out_cell_word),
    .out_scrolled  (out_scrolled)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("** text_console_char_writer: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  function automatic bit advance_cursor();
    cursor_col_q++;
    if (cursor_col_q >= COLUMNS) begin
      cursor_col_q = 0;
      cursor_row_q++;
      if (cursor_row_q >= ROWS) begin
        // everything moves up one row, bottom row goes blank
        for (int i = 0; i < CELLS - COLUMNS; i++) screen_cells[i] = screen_cells[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_cells[i] = '0;
        cursor_row_q = ROWS - 1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic console_result_t step_console(input tcw_pkg::mode_t m,
                                                   input logic [CharW-1:0] ch,
                                                   input logic [ColourW-1:0] fg,
                                                   input logic [ColourW-1:0] bg,
                                                   input logic [RowW-1:0] trow,
                                                   input logic [ColW-1:0] tcol);
    console_result_t res;
    res = '0;
    case (m)
      tcw_pkg::MODE_PRINT: begin
        if (ch == tcw_pkg::CH_BACKSPACE) begin
          if (cursor_col_q > 0) begin
            cursor_col_q--;
            screen_cells[cursor_row_q * COLUMNS + cursor_col_q] = {bg, fg, tcw_pkg::CH_NULL};
          end
        end else if (ch == tcw_pkg::CH_NEWLINE) begin
          // last column is left as it is
          for (int i = cursor_col_q; i < COLUMNS - 1; i++)
            screen_cells[cursor_row_q * COLUMNS + i] = {8'h00, tcw_pkg::CH_SPACE};
          cursor_col_q = COLUMNS - 1;
          res.scrolled = advance_cursor();
        end else if (ch != tcw_pkg::CH_NULL) begin
          screen_cells[cursor_row_q * COLUMNS + cursor_col_q] = {bg, fg, ch};
          res.scrolled = advance_cursor();
        end
      end
      tcw_pkg::MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_cells[i] = {bg, 4'h0, 8'h00};
        cursor_row_q = 0;
        cursor_col_q = 0;
      end
      tcw_pkg::MODE_SET_CURSOR: begin
        cursor_row_q = (int'(trow) < ROWS) ? int'(trow) : ROWS - 1;
        cursor_col_q = (int'(tcol) < COLUMNS) ? int'(tcol) : COLUMNS - 1;
      end
      default: begin
        if (int'(trow) < ROWS && int'(tcol) < COLUMNS)
          res.word = screen_cells[int'(trow) * COLUMNS + int'(tcol)];
      end
    endcase
    res.row = cursor_row_q[RowW-1:0];
    res.col = cursor_col_q[ColW-1:0];
    return res;
  endfunction

  // drives one item and holds it until the block takes it
  task automatic send_cmd(input tcw_pkg::mode_t m, input logic [CharW-1:0] ch,
                          input logic [ColourW-1:0] fg, input logic [ColourW-1:0] bg,
                          input logic [RowW-1:0] trow, input logic [ColW-1:0] tcol);
    console_result_t want;
    if (idle_on && $urandom_range(99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start         <= 1'b1;
    in_mode       <= m;
    in_char_code  <= ch;
    in_fg_colour  <= fg;
    in_bg_colour  <= bg;
    in_target_row <= trow;
    in_target_col <= tcol;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    want = step_console(m, ch, fg, bg, trow, tcol);
    expected_results.push_back(want);
    case (m)
      tcw_pkg::MODE_PRINT:      n_prints++;
      tcw_pkg::MODE_CLEAR:      n_clears++;
      tcw_pkg::MODE_SET_CURSOR: n_moves++;
      default:                  n_reads++;
    endcase
    if (want.scrolled) n_scrolls++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    console_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_cursor_row !== want.row)
          report_mismatch($sformatf("cursor_row got %0d want %0d", out_cursor_row, want.row));
        if (out_cursor_col !== want.col)
          report_mismatch($sformatf("cursor_col got %0d want %0d", out_cursor_col, want.col));
        if (out_cell_word !== want.word)
          report_mismatch($sformatf("cell_word got %h want %h", out_cell_word, want.word));
        if (out_scrolled !== want.scrolled)
          report_mismatch($sformatf("scrolled got %b want %b", out_scrolled, want.scrolled));
      end
    end
  end

  task automatic test_power_up();
    send_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0);
    send_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, RowW'(ROWS - 1), ColW'(COLUMNS - 1));
  endtask

  task automatic test_print_and_wrap();
    send_cmd(tcw_pkg::MODE_SET_CURSOR, 8'h00, 4'h0, 4'h0, 5'd0, ColW'(COLUMNS - 2));
    send_cmd(tcw_pkg::MODE_PRINT, 8'h41, 4'hf, 4'hf, 5'd0, 7'd0);
    // fills the last column and wraps to the next row
    send_cmd(tcw_pkg::MODE_PRINT, 8'hff, 4'h0, 4'h0, 5'd31, 7'd127);
    send_cmd(tcw_pkg::MODE_PRINT, tcw_pkg::CH_NULL, 4'hf, 4'hf, 5'd0, 7'd0);
    send_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 5'd0, ColW'(COLUMNS - 2));
    send_cmd(tcw_pkg::MODE_READ, 8'hff, 4'hf, 4'hf, 5'd0, ColW'(COLUMNS - 1));
  endtask

  task automatic test_control_chars();
    // backspace on column zero is a no-op
    send_cmd(tcw_pkg::MODE_PRINT, tcw_pkg::CH_BACKSPACE, 4'h5, 4'ha, 5'd0, 7'd0);
    send_cmd(tcw_pkg::MODE_SET_CURSOR, 8'h00, 4'h0, 4'h0, 5'd2, 7'd10);
    send_cmd(tcw_pkg::MODE_PRINT, tcw_pkg::CH_BACKSPACE, 4'h5, 4'ha, 5'd0, 7'd0);
    send_cmd(tcw_pkg::MODE_PRINT, tcw_pkg::CH_NEWLINE, 4'hf, 4'hf, 5'd0, 7'd0);
    send_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 5'd2, 7'd9);
    send_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 5'd2, ColW'(COLUMNS - 1));
    send_cmd(tcw_pkg::MODE_SET_CURSOR, 8'h00, 4'h0, 4'h0, 5'd3, ColW'(COLUMNS - 1));
    send_cmd(tcw_pkg::MODE_PRINT, tcw_pkg::CH_NEWLINE, 4'h0, 4'h0, 5'd0, 7'd0);
  endtask

  task automatic test_scroll_and_limits();
    send_cmd(tcw_pkg::MODE_SET_CURSOR, 8'h00, 4'h0, 4'h0, 5'd31, 7'd127);
    send_cmd(tcw_pkg::MODE_PRINT, 8'h7e, 4'hf, 4'h0, 5'd0, 7'd0);
    send_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, RowW'(ROWS - 2), ColW'(COLUMNS - 1));
    send_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, RowW'(ROWS), 7'd0);
    send_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 5'd0, ColW'(COLUMNS));
    send_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 5'd31, 7'd127);
    send_cmd(tcw_pkg::MODE_SET_CURSOR, 8'h00, 4'h0, 4'h0, RowW'(ROWS - 1), 7'd3);
    send_cmd(tcw_pkg::MODE_PRINT, tcw_pkg::CH_NEWLINE, 4'h3, 4'hc, 5'd0, 7'd0);
  endtask

  task automatic test_clear();
    send_cmd(tcw_pkg::MODE_CLEAR, 8'h00, 4'h0, 4'hf, 5'd0, 7'd0);
    send_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 5'd12, 7'd40);
    send_cmd(tcw_pkg::MODE_CLEAR, 8'hff, 4'hf, 4'h0, 5'd31, 7'd127);
  endtask

  task automatic test_random_traffic(input int n_items);
    int                 pick;
    int                 sel;
    logic [CharW-1:0]   ch;
    logic [RowW-1:0]    trow;
    logic [ColW-1:0]    tcol;
    for (int k = 0; k < n_items; k++) begin
      // one long stretch with no idling
      idle_on = !(k >= 150 && k < 280);
      if (k == n_items / 2) wait_drained();
      pick = $urandom_range(99);
      if (pick < 65) begin
        sel = $urandom_range(99);
        if (sel < 8)       ch = tcw_pkg::CH_NEWLINE;
        else if (sel < 14) ch = tcw_pkg::CH_BACKSPACE;
        else if (sel < 17) ch = tcw_pkg::CH_NULL;
        else               ch = CharW'($urandom_range(255));
        send_cmd(tcw_pkg::MODE_PRINT, ch, ColourW'($urandom_range(15)),
                 ColourW'($urandom_range(15)), RowW'($urandom_range(31)),
                 ColW'($urandom_range(127)));
      end else if (pick < 75) begin
        // lean toward the bottom rows and the right edge so scrolls and wraps happen
        trow = ($urandom_range(2) == 0) ? RowW'($urandom_range(31))
                                        : RowW'($urandom_range(ROWS - 1, ROWS - 4));
        tcol = ($urandom_range(2) == 0) ? ColW'($urandom_range(127))
                                        : ColW'($urandom_range(COLUMNS - 1, COLUMNS - 6));
        send_cmd(tcw_pkg::MODE_SET_CURSOR, CharW'($urandom_range(255)),
                 ColourW'($urandom_range(15)), ColourW'($urandom_range(15)), trow, tcol);
      end else if (pick < 98) begin
        if ($urandom_range(3) == 0) begin
          trow = RowW'($urandom_range(31));
          tcol = ColW'($urandom_range(127));
        end else begin
          // half of these look at the row the cursor is on, the rest at any valid row
          trow = ($urandom_range(1) == 0) ? RowW'(cursor_row_q)
                                          : RowW'($urandom_range(ROWS - 1));
          tcol = ColW'($urandom_range(COLUMNS - 1));
        end
        send_cmd(tcw_pkg::MODE_READ, CharW'($urandom_range(255)),
                 ColourW'($urandom_range(15)), ColourW'($urandom_range(15)), trow, tcol);
      end else begin
        send_cmd(tcw_pkg::MODE_CLEAR, CharW'($urandom_range(255)),
                 ColourW'($urandom_range(15)), ColourW'($urandom_range(15)),
                 RowW'($urandom_range(31)), ColW'($urandom_range(127)));
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_mode       <= tcw_pkg::MODE_PRINT;
    in_char_code  <= '0;
    in_fg_colour  <= '0;
    in_bg_colour  <= '0;
    in_target_row <= '0;
    in_target_col <= '0;
    error_count = 0;
    idle_on     = 1'b1;
    n_prints = 0; n_clears = 0; n_moves = 0; n_reads = 0; n_scrolls = 0;
    for (int i = 0; i < CELLS; i++) screen_cells[i] = '0;
    cursor_row_q = 0;
    cursor_col_q = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_power_up();
    test_print_and_wrap();
    test_control_chars();
    test_scroll_and_limits();
    test_clear();
    test_random_traffic(425);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d prints, %0d clears, %0d cursor moves, %0d reads", n_prints, n_clears,
             n_moves, n_reads);
    $display("screen scrolled %0d times; %0d mismatches", n_scrolls, error_count);
    if (error_count == 0) begin
      $display("** text_console_char_writer: PASSED **");
    end else begin
      $display("** text_console_char_writer: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
design/tcw_pkg.sv
design/tcw_cell_ram.sv
design/text_console_char_writer.sv
sim/tb_text_console_char_writer.sv
